// ===== design/dbd_pkg.sv =====
// Shared types, constants and calendar functions for the date distance block.
package dbd_pkg;

   localparam int YEAR_BITS  = 12;
   localparam int DAY_BITS   = 5;
   localparam int MONTH_BITS = 4;
   localparam int COUNT_BITS = 21;
   localparam int DOY_BITS   = 9;
   localparam int LEN_BITS   = 5;
   // signed accumulator: up to 2^YEAR_BITS years of at most 366 days, plus sign
   localparam int ACC_BITS   = YEAR_BITS + 10;

   // multiplicative inverse of 25 modulo 2^16; y is a multiple of 25 exactly when
   // y * inverse (mod 2^n) does not exceed (2^n - 1) / 25
   localparam logic [15:0]          INV25_WIDE = 16'h5C29;
   localparam logic [YEAR_BITS-1:0] INV25      = INV25_WIDE[YEAR_BITS-1:0];
   localparam logic [YEAR_BITS-1:0] DIV25_MAX  = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

   localparam logic [ACC_BITS-1:0] DAYS_COMMON = ACC_BITS'(365);
   localparam logic [ACC_BITS-1:0] DAYS_LEAP   = ACC_BITS'(366);

   localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_BITS-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_BITS-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_BITS-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_BITS-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_BITS-1:0]   first_day;
      logic [MONTH_BITS-1:0] first_month;
      logic [YEAR_BITS-1:0]  first_year;
      logic [DAY_BITS-1:0]   second_day;
      logic [MONTH_BITS-1:0] second_month;
      logic [YEAR_BITS-1:0]  second_year;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] day_count;
      logic                  invalid_date;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic leap_a;
      logic leap_b;
      logic prep;
      logic walk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic same_year;
      logic walk_last;
      logic out_free;
   } status_type;

   function automatic logic [LEN_BITS-1:0] month_length(input logic [MONTH_BITS-1:0] month,
                                                        input logic leap);
      logic [LEN_BITS-1:0] len;
      if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         len = 5'd30;
      end else if (month == MONTH_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

   function automatic logic [DOY_BITS-1:0] days_before(input logic [MONTH_BITS-1:0] month);
      logic [DOY_BITS-1:0] days;
      case (month)
         MONTH_JAN: days = 9'd0;
         MONTH_FEB: days = 9'd31;
         MONTH_MAR: days = 9'd59;
         MONTH_APR: days = 9'd90;
         MONTH_MAY: days = 9'd120;
         MONTH_JUN: days = 9'd151;
         MONTH_JUL: days = 9'd181;
         MONTH_AUG: days = 9'd212;
         MONTH_SEP: days = 9'd243;
         MONTH_OCT: days = 9'd273;
         MONTH_NOV: days = 9'd304;
         MONTH_DEC: days = 9'd334;
         default:   days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== design/dbd_ctrl.sv =====
// Sequencer for the date distance block: steps the datapath through one item.
module dbd_ctrl
   import dbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LEAP_A = 6'b000010,
      ST_LEAP_B = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LEAP_A;
            end
         end
         ST_LEAP_A: begin
            cmd.leap_a = 1'b1;
            state_in   = ST_LEAP_B;
         end
         ST_LEAP_B: begin
            cmd.leap_b = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            // skip the year walk for a bad date or when both years match
            if (status.bad || status.same_year) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the item
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/dbd_datapath.sv =====
// Datapath for the date distance block: leap test, day-of-year, year walk, output register.
module dbd_datapath
   import dbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   req_type                req_ff;
   logic                   leap1_ff;
   logic                   leap2_ff;
   logic                   bad_ff;
   logic                   bad_in;
   logic [YEAR_BITS-1:0]   cur_ff;
   logic [YEAR_BITS-1:0]   end_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic [ACC_BITS-1:0]    acc_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [YEAR_BITS-1:0]   year_sel;
   logic [YEAR_BITS-1:0]   prod;
   logic                   div25;
   logic                   leap;

   logic [DOY_BITS-1:0]    doy1;
   logic [DOY_BITS-1:0]    doy2;
   logic                   ok1;
   logic                   ok2;
   logic                   first_low;
   logic [DOY_BITS-1:0]    doy_lo;
   logic [DOY_BITS-1:0]    doy_hi;
   logic [ACC_BITS-1:0]    mag;
   logic                   out_free;

   // shared leap test: divisible by 4, and not by 100 unless by 400
   always_comb begin
      if (cmd.leap_a) begin
         year_sel = req_ff.first_year;
      end else if (cmd.leap_b) begin
         year_sel = req_ff.second_year;
      end else begin
         year_sel = cur_ff;
      end
      prod  = year_sel * INV25;
      div25 = (prod <= DIV25_MAX);
      leap  = (year_sel[1:0] == 2'd0) && (!div25 || (year_sel[3:0] == 4'd0));
   end

   // day of year and date check for both dates
   always_comb begin
      doy1 = days_before(req_ff.first_month) + DOY_BITS'(req_ff.first_day) - 9'd1
             + DOY_BITS'(leap1_ff && (req_ff.first_month > MONTH_FEB));
      doy2 = days_before(req_ff.second_month) + DOY_BITS'(req_ff.second_day) - 9'd1
             + DOY_BITS'(leap2_ff && (req_ff.second_month > MONTH_FEB));
      ok1  = (req_ff.first_month >= MONTH_JAN) && (req_ff.first_month <= MONTH_DEC)
             && (req_ff.first_day != '0)
             && (req_ff.first_day <= month_length(req_ff.first_month, leap1_ff));
      ok2  = (req_ff.second_month >= MONTH_JAN) && (req_ff.second_month <= MONTH_DEC)
             && (req_ff.second_day != '0)
             && (req_ff.second_day <= month_length(req_ff.second_month, leap2_ff));
      bad_in    = !(ok1 && ok2);
      first_low = (req_ff.first_year <= req_ff.second_year);
      doy_lo    = first_low ? doy1 : doy2;
      doy_hi    = first_low ? doy2 : doy1;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.prep) begin
         acc_in = ACC_BITS'(doy_hi) - ACC_BITS'(doy_lo);
      end else if (cmd.walk) begin
         acc_in = acc_ff + (leap ? DAYS_LEAP : DAYS_COMMON);
      end
   end

   assign mag      = acc_ff[ACC_BITS-1] ? (~acc_ff + ACC_BITS'(1)) : acc_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.bad       = bad_in;
   assign status.same_year = (req_ff.first_year == req_ff.second_year);
   assign status.walk_last = ((cur_ff + YEAR_BITS'(1)) == end_ff);
   assign status.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.leap_a) begin
         leap1_ff <= leap;
      end
      if (cmd.leap_b) begin
         leap2_ff <= leap;
      end
      if (cmd.prep) begin
         bad_ff <= bad_in;
         cur_ff <= first_low ? req_ff.first_year : req_ff.second_year;
         end_ff <= first_low ? req_ff.second_year : req_ff.first_year;
      end else if (cmd.walk) begin
         cur_ff <= cur_ff + YEAR_BITS'(1);
      end
      acc_ff <= acc_in;
      if (cmd.finish) begin
         rsp_ff.invalid_date <= bad_ff;
         rsp_ff.day_count    <= bad_ff ? '0 : mag[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_walk_below_end: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (cur_ff < end_ff))
      else $error("year walk ran past the later year");

   a_walk_nonneg: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |=> !acc_ff[ACC_BITS-1])
      else $error("day accumulator negative after a year step");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.invalid_date) |-> (rsp_ff.day_count == '0))
      else $error("invalid item carries a nonzero count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");
`endif

endmodule

// ===== design/days_between_dates.sv =====
// Top level of the Gregorian date distance block.
//
// Takes one item on the req_ channel: two dates, each day, month and year.
// Returns one item on the rsp_ channel: the absolute day count between them,
// or invalid_date set with a count of zero when either date has a month
// outside 1..12 or a day of zero or beyond its month's length.
// Both channels hand over an item at a clock edge with valid high, stall low.
//
// After an item is accepted, the sequencer runs the leap test of each year
// in turn, a prep step, the year walk and a finish step that loads the
// output register; prep goes straight to finish when the years match or a
// date is invalid. The year walk adds one year length per cycle through a
// single leap-year unit; the next item is accepted only back in idle.
//
// The finished item sits in an output register; a new item is taken while it
// waits. If rsp_stall holds it, the next result waits in the sequencer until
// the register frees up. Synchronous reset returns the sequencer to idle and
// drops any pending result.
module days_between_dates
   import dbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   dbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dbd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/dbd_distance_checker.sv =====
// Checker for the date distance block: predicts each day count and compares results.
module dbd_distance_checker
   import dbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      result_count,
   output int      invalid_count
);

   // predicted results, oldest item first
   rsp_type pending_distances[$];

   function automatic bit leap_year(input int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned days_in_month(input logic [MONTH_BITS-1:0] month,
                                                 input int unsigned year);
      int unsigned len;
      case (month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
         MONTH_FEB: len = leap_year(year) ? 29 : 28;
         default:   len = 31;
      endcase
      return len;
   endfunction

   function automatic bit date_valid(input logic [DAY_BITS-1:0] day,
                                     input logic [MONTH_BITS-1:0] month,
                                     input logic [YEAR_BITS-1:0] year);
      return (month >= MONTH_JAN) && (month <= MONTH_DEC) && (day >= 1) &&
             (day <= days_in_month(month, year));
   endfunction

   // days elapsed since 1 January of year zero
   function automatic int unsigned day_number(input logic [DAY_BITS-1:0] day,
                                              input logic [MONTH_BITS-1:0] month,
                                              input logic [YEAR_BITS-1:0] year);
      int unsigned y;
      int unsigned n;
      y = year;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + day - 1;
      for (int k = MONTH_JAN; k < month; k++) begin
         n += days_in_month(MONTH_BITS'(k), y);
      end
      return n;
   endfunction

   function automatic rsp_type expected_distance(input req_type pair);
      rsp_type     want;
      int unsigned a;
      int unsigned b;
      want = '0;
      if (!date_valid(pair.first_day, pair.first_month, pair.first_year) ||
          !date_valid(pair.second_day, pair.second_month, pair.second_year)) begin
         want.invalid_date = 1'b1;
      end else begin
         a = day_number(pair.first_day, pair.first_month, pair.first_year);
         b = day_number(pair.second_day, pair.second_month, pair.second_year);
         want.day_count = COUNT_BITS'((a > b) ? a - b : b - a);
      end
      return want;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
         result_count  <= 0;
         invalid_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_distances.push_back(expected_distance(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (rsp_data.invalid_date === 1'b1) begin
               invalid_count <= invalid_count + 1;
            end
            if (pending_distances.size() == 0) begin
               $display("%0t: unexpected result, expected none, got day_count %0d invalid %0b",
                        $time, rsp_data.day_count, rsp_data.invalid_date);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_distances.pop_front();
               if (rsp_data.day_count !== want.day_count ||
                   rsp_data.invalid_date !== want.invalid_date) begin
                  if (rsp_data.day_count !== want.day_count) begin
                     $display("%0t: day_count mismatch, expected %0d, got %0d",
                              $time, want.day_count, rsp_data.day_count);
                  end
                  if (rsp_data.invalid_date !== want.invalid_date) begin
                     $display("%0t: invalid_date mismatch, expected %0b, got %0b",
                              $time, want.invalid_date, rsp_data.invalid_date);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= pending_distances.size();
      end
   end

endmodule

// ===== test/days_between_dates_tb.sv =====
// Testbench top for the date distance block: stimulus, receiver stalls and verdict.
module days_between_dates_tb;
   import dbd_pkg::*;

   localparam int RANDOM_PAIRS = 1630;
   localparam int YEAR_MAX     = (1 << YEAR_BITS) - 1;
   // bound on the whole run, with plenty of slack over the slowest expected run
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_mode_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int result_count;
   int invalid_count;
   int cycle_count = 0;
   int sent        = 0;
   int burst_left  = 1;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   days_between_dates u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dbd_distance_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .invalid_count (invalid_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("days_between_dates verification failed");
         $finish;
      end
   end

   // receiver: switch between randomly chosen stall patterns
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(STALL_NONE, STALL_HEAVY));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_HALF: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_RARE: rsp_stall <= ($urandom_range(0, 7) == 0);
         default:    rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   function automatic req_type make_pair(input int d1, input int m1, input int y1,
                                         input int d2, input int m2, input int y2);
      req_type pair;
      pair.first_day    = DAY_BITS'(d1);
      pair.first_month  = MONTH_BITS'(m1);
      pair.first_year   = YEAR_BITS'(y1);
      pair.second_day   = DAY_BITS'(d2);
      pair.second_month = MONTH_BITS'(m2);
      pair.second_year  = YEAR_BITS'(y2);
      return pair;
   endfunction

   // lean on century and 400-year boundaries now and then
   function automatic int pick_year();
      int year;
      case ($urandom_range(0, 7))
         0:       year = $urandom_range(0, 40) * 100;
         1:       year = $urandom_range(0, 10) * 400;
         default: year = $urandom_range(0, YEAR_MAX);
      endcase
      return year;
   endfunction

   function automatic int pick_day();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
   endfunction

   function automatic logic [MONTH_BITS-1:0] short_month();
      logic [MONTH_BITS-1:0] month;
      case ($urandom_range(0, 4))
         0:       month = MONTH_FEB;
         1:       month = MONTH_APR;
         2:       month = MONTH_JUN;
         3:       month = MONTH_SEP;
         default: month = MONTH_NOV;
      endcase
      return month;
   endfunction

   function automatic req_type random_pair();
      req_type pair;
      int      kind;
      int      y2;
      kind = $urandom_range(0, 99);
      pair = make_pair(pick_day(), $urandom_range(MONTH_JAN, MONTH_DEC), pick_year(),
                       pick_day(), $urandom_range(MONTH_JAN, MONTH_DEC), 0);
      if (kind < 5) begin
         pair.second_year = YEAR_BITS'(pick_year());
      end else if (kind < 10) begin
         pair.second_day   = pair.first_day;
         pair.second_month = pair.first_month;
         pair.second_year  = pair.first_year;
      end else begin
         // keep most pairs within a couple of years, since the block walks the years between them
         y2 = int'(pair.first_year) + int'($urandom_range(0, 4)) - 2;
         if (y2 < 0) y2 = 0;
         if (y2 > YEAR_MAX) y2 = YEAR_MAX;
         pair.second_year = YEAR_BITS'(y2);
      end
      if (kind >= 85) begin
         case ($urandom_range(0, 4))
            // 16 truncates to zero, so this covers 0 and 13..15
            0: pair.first_month = MONTH_BITS'($urandom_range(13, 16));
            1: pair.second_month = MONTH_BITS'($urandom_range(13, 16));
            2: pair.first_day = '0;
            3: begin
               pair.second_month = short_month();
               pair.second_day   = DAY_BITS'($urandom_range(29, 31));
            end
            default: begin
               pair.first_day    = DAY_BITS'($urandom);
               pair.first_month  = MONTH_BITS'($urandom);
               pair.second_day   = DAY_BITS'($urandom);
               pair.second_month = MONTH_BITS'($urandom);
            end
         endcase
      end
      return pair;
   endfunction

   task automatic send_pair(input req_type pair);
      int gap;
      req_data  <= pair;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // hold off the sender until every outstanding item has its result
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, leap rules, malformed dates, ordering
      send_pair(make_pair(1, MONTH_JAN, 0, 1, MONTH_JAN, 0));
      send_pair(make_pair(1, MONTH_JAN, 0, 31, MONTH_DEC, YEAR_MAX));
      send_pair(make_pair(31, MONTH_DEC, YEAR_MAX, 1, MONTH_JAN, 0));
      send_pair(make_pair(31, MONTH_DEC, YEAR_MAX, 31, MONTH_DEC, YEAR_MAX));
      send_pair(make_pair(29, MONTH_FEB, 2000, 1, MONTH_MAR, 2000));
      send_pair(make_pair(29, MONTH_FEB, 1900, 1, MONTH_MAR, 1900));
      send_pair(make_pair(29, MONTH_FEB, 2004, 28, MONTH_FEB, 2005));
      send_pair(make_pair(29, MONTH_FEB, 0, 1, MONTH_JAN, 1));
      send_pair(make_pair(29, MONTH_FEB, 2100, 1, MONTH_MAR, 2100));
      send_pair(make_pair(29, MONTH_FEB, 2400, 29, MONTH_FEB, 2396));
      send_pair(make_pair(28, MONTH_FEB, 2001, 1, MONTH_MAR, 2001));
      send_pair(make_pair(0, MONTH_MAY, 2020, 1, MONTH_MAY, 2020));
      send_pair(make_pair(31, MONTH_APR, 2021, 1, MONTH_MAY, 2021));
      send_pair(make_pair(15, 13, 2020, 15, MONTH_JUN, 2020));
      send_pair(make_pair(1, 0, 2020, 1, MONTH_JAN, 2020));
      send_pair(make_pair(1, MONTH_JAN, 2000, 31, 15, YEAR_MAX));
      send_pair(make_pair(1, MONTH_JAN, 2000, 31, MONTH_JUN, 2000));
      send_pair(make_pair(31, 15, YEAR_MAX, 31, 14, YEAR_MAX));
      send_pair(make_pair(31, MONTH_DEC, 1999, 1, MONTH_JAN, 2000));
      send_pair(make_pair(30, MONTH_NOV, 2023, 1, MONTH_DEC, 2023));
      send_pair(make_pair(31, MONTH_JAN, 2023, 1, MONTH_FEB, 2023));
      send_pair(make_pair(15, MONTH_JUN, 2010, 14, MONTH_JUN, 2010));
      drain_results();

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         send_pair(random_pair());
         if (i % 400 == 399) drain_results();
      end
      drain_results();
      // catch any stray result before the verdict
      repeat (40) @(posedge clock);

      $display("%0d date pairs sent (directed extremes plus random), %0d results checked",
               sent, result_count);
      $display("%0d results flagged invalid, %0d cycles run", invalid_count, cycle_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("days_between_dates verification clean");
      end else begin
         $display("days_between_dates verification failed");
      end
      $finish;
   end

endmodule
